// ----- sv/usage_event_statistics_top_assert.svh -----
// Assertion macros for the usage event statistics block.
`ifndef USAGE_EVENT_STATISTICS_TOP_ASSERT_SVH
`define USAGE_EVENT_STATISTICS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UES_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define UES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ues_pkg.sv -----
// Package with constants and types of the usage event statistics block.
`default_nettype none

package ues_pkg;

	// Field and register widths
	localparam int FUNC_W     = 2;
	localparam int SAMPLE_W   = 8;
	localparam int SEL_W      = 3;
	localparam int TOTAL_W    = 32;
	localparam int DAY_W      = 16;
	localparam int SPD_W      = 17;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// Default history depth
	localparam int HISTORY_DAYS_DEF = 5;

	// Register reset values
	localparam logic [SAMPLE_W-1:0] MIN_SESSION_RST = 8'd5;
	localparam logic [TOTAL_W-1:0]  TIME_LIMIT_RST  = 32'hFFFF_FFFF;
	localparam logic [TOTAL_W-1:0]  COUNT_LIMIT_RST = 32'hFFFF_FFFF;
	localparam logic [DAY_W-1:0]    DAY_LIMIT_RST   = 16'hFFFF;
	localparam logic [SPD_W-1:0]    SPD_RST         = 17'd86400;

	// Transaction function codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_TICK   = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	// Register indexes (word address)
	typedef enum logic [2:0] {
		REG_MIN_SESSION = 3'd0,
		REG_TIME_LIMIT  = 3'd1,
		REG_COUNT_LIMIT = 3'd2,
		REG_DAY_LIMIT   = 3'd3,
		REG_SPD         = 3'd4
	} reg_idx_t;

endpackage

`default_nettype wire

// ----- sv/usage_event_statistics_top.sv -----
// Top level of the usage event statistics block.
// A transaction is held in the input register and then in the result register, which drives the output;
// it waits in the input register only while the result register waits for out_ready.
// Throughput: one transaction per cycle; the input register and the result register
// form a two-stage pipeline that advances whenever the result register is free or taken.
// Reset: arst_n clears all statistics and pipeline valids and loads register defaults;
// the block is ready for a transaction as soon as reset is released.
`default_nettype none

module usage_event_statistics_top
	import ues_pkg::*;
#(
	parameter int HISTORY_DAYS = HISTORY_DAYS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input channel
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [FUNC_W-1:0]     func,
	input  wire logic [SAMPLE_W-1:0]   session_seconds,
	input  wire logic [SEL_W-1:0]      day_select,
	// output channel
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [TOTAL_W-1:0]         total_count,
	output logic [TOTAL_W-1:0]         total_time,
	output logic [DAY_W-1:0]           today_count,
	output logic [DAY_W-1:0]           selected_day_count,
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	// Configuration registers
	logic [SAMPLE_W-1:0] min_session_q;
	logic [TOTAL_W-1:0]  time_limit_q;
	logic [TOTAL_W-1:0]  count_limit_q;
	logic [DAY_W-1:0]    day_limit_q;
	logic [SPD_W-1:0]    spd_q;

	// Statistics state
	logic                session_active_q;
	logic [SAMPLE_W-1:0] last_sample_q;
	logic [TOTAL_W-1:0]  time_total_q;
	logic [TOTAL_W-1:0]  count_total_q;
	logic [DAY_W-1:0]    hist_q [HISTORY_DAYS];
	logic [SPD_W-1:0]    sec_cnt_q;

	// Next state
	logic                session_active_d;
	logic [SAMPLE_W-1:0] last_sample_d;
	logic [TOTAL_W-1:0]  time_total_d;
	logic [TOTAL_W-1:0]  count_total_d;
	logic [DAY_W-1:0]    hist_d [HISTORY_DAYS];
	logic [SPD_W-1:0]    sec_cnt_d;
	logic [DAY_W-1:0]    picked;

	// Stage 1: input register
	logic                valid_s1;
	logic [FUNC_W-1:0]   func_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SEL_W-1:0]    sel_s1;

	// Stage 2: result register
	logic                valid_s2;
	logic [TOTAL_W-1:0]  count_s2;
	logic [TOTAL_W-1:0]  time_s2;
	logic [DAY_W-1:0]    today_s2;
	logic [DAY_W-1:0]    picked_s2;

	logic                adv;
	logic                step;
	logic                cfg_wr;
	reg_idx_t            cfg_idx;

	// Scratch values for the sample path
	logic [SAMPLE_W-1:0] diff;
	logic [TOTAL_W:0]    sum;
	logic [SPD_W-1:0]    sec_inc;

	// Handshake
	assign adv      = !valid_s2 || out_ready;
	assign step     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (cfg_idx)
			REG_MIN_SESSION: prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, min_session_q};
			REG_TIME_LIMIT:  prdata = time_limit_q;
			REG_COUNT_LIMIT: prdata = count_limit_q;
			REG_DAY_LIMIT:   prdata = {{(APB_DATA_W-DAY_W){1'b0}}, day_limit_q};
			REG_SPD:         prdata = {{(APB_DATA_W-SPD_W){1'b0}}, spd_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_session_q <= MIN_SESSION_RST;
			time_limit_q  <= TIME_LIMIT_RST;
			count_limit_q <= COUNT_LIMIT_RST;
			day_limit_q   <= DAY_LIMIT_RST;
			spd_q         <= SPD_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MIN_SESSION: min_session_q <= pwdata[SAMPLE_W-1:0];
				REG_TIME_LIMIT:  time_limit_q  <= pwdata[TOTAL_W-1:0];
				REG_COUNT_LIMIT: count_limit_q <= pwdata[TOTAL_W-1:0];
				REG_DAY_LIMIT:   day_limit_q   <= pwdata[DAY_W-1:0];
				REG_SPD:         spd_q         <= pwdata[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1   <= func;
			sample_s1 <= session_seconds;
			sel_s1    <= day_select;
		end
	end

	// Next-state logic for one transaction
	always_comb begin
		session_active_d = session_active_q;
		last_sample_d    = last_sample_q;
		time_total_d     = time_total_q;
		count_total_d    = count_total_q;
		sec_cnt_d        = sec_cnt_q;
		for (int k = 0; k < HISTORY_DAYS; k++) begin
			hist_d[k] = hist_q[k];
		end
		diff    = sample_s1 - last_sample_q;
		sum     = {1'b0, time_total_q} + {{(TOTAL_W+1-SAMPLE_W){1'b0}}, diff};
		sec_inc = sec_cnt_q + 1'b1;

		unique case (func_t'(func_s1))
			FUNC_SAMPLE: begin
				if (sample_s1 < min_session_q) begin
					// below minimum: re-arm detector
					session_active_d = 1'b0;
					last_sample_d    = '0;
				end else begin
					if (diff != '0) begin
						time_total_d  = (sum > {1'b0, time_limit_q}) ?
							time_limit_q : sum[TOTAL_W-1:0];
						last_sample_d = sample_s1;
					end
					// first qualifying sample of a session
					if (!session_active_q) begin
						session_active_d = 1'b1;
						if (count_total_q < count_limit_q) begin
							count_total_d = count_total_q + 1'b1;
						end
						if (hist_q[0] < day_limit_q) begin
							hist_d[0] = hist_q[0] + 1'b1;
						end
					end
				end
			end
			FUNC_TICK: begin
				if (sec_inc >= spd_q) begin
					// day complete: shift history
					sec_cnt_d = '0;
					for (int k = HISTORY_DAYS - 1; k > 0; k--) begin
						hist_d[k] = hist_q[k-1];
					end
					hist_d[0] = '0;
				end else begin
					sec_cnt_d = sec_inc;
				end
			end
			FUNC_CLEAR: begin
				time_total_d  = '0;
				count_total_d = '0;
				sec_cnt_d     = '0;
				for (int k = 0; k < HISTORY_DAYS; k++) begin
					hist_d[k] = '0;
				end
			end
			default: ;
		endcase

		// History day pick, zero when out of range
		picked = '0;
		for (int k = 0; k < HISTORY_DAYS; k++) begin
			if ({2'b00, sel_s1} == 5'(k + 1)) begin
				picked = hist_d[k];
			end
		end
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_active_q <= 1'b0;
			last_sample_q    <= '0;
			time_total_q     <= '0;
			count_total_q    <= '0;
			sec_cnt_q        <= '0;
			for (int k = 0; k < HISTORY_DAYS; k++) begin
				hist_q[k] <= '0;
			end
		end else if (step) begin
			session_active_q <= session_active_d;
			last_sample_q    <= last_sample_d;
			time_total_q     <= time_total_d;
			count_total_q    <= count_total_d;
			sec_cnt_q        <= sec_cnt_d;
			for (int k = 0; k < HISTORY_DAYS; k++) begin
				hist_q[k] <= hist_d[k];
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			count_s2  <= count_total_d;
			time_s2   <= time_total_d;
			today_s2  <= hist_d[0];
			picked_s2 <= picked;
		end
	end

	assign out_valid          = valid_s2;
	assign total_count        = count_s2;
	assign total_time         = time_s2;
	assign today_count        = today_s2;
	assign selected_day_count = picked_s2;

	// Checks
	`include "usage_event_statistics_top_assert.svh"

	`UES_ASSERT_NEXT(a_step_gives_result, step, out_valid,
		"stage 1 advanced without a result")
	`UES_ASSERT_SAME(a_stall_blocks_input, out_valid && !out_ready && valid_s1, !in_ready,
		"input taken while both stages are full")
	`UES_ASSERT_NEXT(a_clear_zeroes, step && func_s1 == FUNC_CLEAR,
		count_total_q == '0 && time_total_q == '0 && hist_q[0] == '0 && sec_cnt_q == '0,
		"clear left statistics nonzero")
	`UES_ASSERT_NEXT(a_day_counter_range, step && func_s1 == FUNC_TICK && !cfg_wr,
		sec_cnt_q == '0 || sec_cnt_q < spd_q,
		"second counter not below day length after a tick")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench for the usage event statistics block: directed and random transactions checked against a predictor.
module tb;
	import ues_pkg::*;

	// Unused function code: no state change, result still reported
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS = 420;

	typedef struct packed {
		logic [TOTAL_W-1:0] total_count;
		logic [TOTAL_W-1:0] total_time;
		logic [DAY_W-1:0]   today_count;
		logic [DAY_W-1:0]   selected_day_count;
	} usage_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [FUNC_W-1:0]     func = FUNC_SAMPLE;
	logic [SAMPLE_W-1:0]   session_seconds = '0;
	logic [SEL_W-1:0]      day_select = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [TOTAL_W-1:0]    total_count;
	logic [TOTAL_W-1:0]    total_time;
	logic [DAY_W-1:0]      today_count;
	logic [DAY_W-1:0]      selected_day_count;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	usage_event_statistics_top DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.func               (func),
		.session_seconds    (session_seconds),
		.day_select         (day_select),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.total_count        (total_count),
		.total_time         (total_time),
		.today_count        (today_count),
		.selected_day_count (selected_day_count),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready)
	);

	// Predictor copy of the registers
	logic [SAMPLE_W-1:0] cfg_min_session = MIN_SESSION_RST;
	logic [TOTAL_W-1:0]  cfg_time_limit  = TIME_LIMIT_RST;
	logic [TOTAL_W-1:0]  cfg_count_limit = COUNT_LIMIT_RST;
	logic [DAY_W-1:0]    cfg_day_limit   = DAY_LIMIT_RST;
	logic [SPD_W-1:0]    cfg_day_seconds = SPD_RST;

	// Predictor copy of the statistics
	logic                session_on = 1'b0;
	logic [SAMPLE_W-1:0] last_seconds = '0;
	logic [TOTAL_W-1:0]  time_acc = '0;
	logic [TOTAL_W-1:0]  count_acc = '0;
	logic [DAY_W-1:0]    day_hist [HISTORY_DAYS_DEF] = '{default: '0};
	logic [SPD_W-1:0]    sec_in_day = '0;

	usage_result_t expected_usage [$];
	usage_result_t oldest_usage;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_settings = 0;
	int n_rollovers = 0;
	int stall_cycles = 0;
	logic [SAMPLE_W-1:0] cur_sample = '0;

	// Clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Applies one transaction to the predicted statistics and returns the expected result
	function automatic usage_result_t predict_usage(input logic [FUNC_W-1:0] f,
			input logic [SAMPLE_W-1:0] s, input logic [SEL_W-1:0] sel);
		logic [SAMPLE_W-1:0] delta;
		logic [TOTAL_W:0]    sum;
		usage_result_t       r;
		case (f)
			FUNC_SAMPLE: begin
				if (s < cfg_min_session) begin
					// short sample re-arms the session detector
					session_on = 1'b0;
					last_seconds = '0;
				end else begin
					delta = s - last_seconds;
					if (delta != 0) begin
						sum = {1'b0, time_acc} + (TOTAL_W + 1)'(delta);
						if (sum > {1'b0, cfg_time_limit})
							sum = {1'b0, cfg_time_limit};
						time_acc = sum[TOTAL_W-1:0];
						last_seconds = s;
					end
					if (!session_on) begin
						session_on = 1'b1;
						if (count_acc < cfg_count_limit)
							count_acc = count_acc + 32'd1;
						if (day_hist[0] < cfg_day_limit)
							day_hist[0] = day_hist[0] + 16'd1;
					end
				end
			end
			FUNC_TICK: begin
				sec_in_day = sec_in_day + 17'd1;
				if (sec_in_day >= cfg_day_seconds) begin
					sec_in_day = '0;
					for (int k = HISTORY_DAYS_DEF - 1; k > 0; k--)
						day_hist[k] = day_hist[k-1];
					day_hist[0] = '0;
					n_rollovers++;
				end
			end
			FUNC_CLEAR: begin
				time_acc = '0;
				count_acc = '0;
				sec_in_day = '0;
				for (int k = 0; k < HISTORY_DAYS_DEF; k++)
					day_hist[k] = '0;
			end
			default: ;
		endcase
		r.total_count = count_acc;
		r.total_time = time_acc;
		r.today_count = day_hist[0];
		r.selected_day_count = '0;
		if (sel >= 1 && sel <= HISTORY_DAYS_DEF)
			r.selected_day_count = day_hist[sel-1];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("ERROR at %0t: %s expected %h, got %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Monitor: predict on input transactions, compare output transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_usage.push_back(predict_usage(func, session_seconds, day_select));
				n_sent++;
			end
			if (out_valid && out_ready) begin
				if (expected_usage.size() == 0) begin
					$display("ERROR at %0t: result with nothing pending, count %h time %h",
						$time, total_count, total_time);
					mismatch_count++;
				end else begin
					oldest_usage = expected_usage.pop_front();
					check_field("total_count", oldest_usage.total_count, total_count);
					check_field("total_time", oldest_usage.total_time, total_time);
					check_field("today_count", 32'(oldest_usage.today_count), 32'(today_count));
					check_field("selected_day_count", 32'(oldest_usage.selected_day_count),
						32'(selected_day_count));
					n_checked++;
				end
			end
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR at %0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Mismatches found");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// Send one transaction, with a random idle gap before it
	task automatic send_usage(input logic [FUNC_W-1:0] f, input logic [SAMPLE_W-1:0] s,
			input logic [SEL_W-1:0] sel);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		func <= f;
		session_seconds <= s;
		day_select <= sel;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Hold the sender until every expected result has arrived
	task automatic drain_usage(input int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_usage.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
	endtask

	// Write all registers while the block is idle
	task automatic write_usage_config(input logic [SAMPLE_W-1:0] min_s,
			input logic [TOTAL_W-1:0] t_lim, input logic [TOTAL_W-1:0] c_lim,
			input logic [DAY_W-1:0] d_lim, input logic [SPD_W-1:0] spd);
		drain_usage(SETTLE_CYCLES);
		apb_write(REG_MIN_SESSION, 32'(min_s));
		apb_write(REG_TIME_LIMIT, t_lim);
		apb_write(REG_COUNT_LIMIT, c_lim);
		apb_write(REG_DAY_LIMIT, 32'(d_lim));
		apb_write(REG_SPD, 32'(spd));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		cfg_min_session = min_s;
		cfg_time_limit = t_lim;
		cfg_count_limit = c_lim;
		cfg_day_limit = d_lim;
		cfg_day_seconds = spd;
		n_settings++;
	endtask

	// Reset settings: thresholds, wrap of the sample difference, clear, unused code, selectors
	task automatic test_directed;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_usage(FUNC_SAMPLE, 8'd0, 3'd1);
		send_usage(FUNC_SAMPLE, 8'd4, 3'd1);
		send_usage(FUNC_SAMPLE, 8'd5, 3'd1);
		send_usage(FUNC_SAMPLE, 8'd5, 3'd2);
		send_usage(FUNC_SAMPLE, 8'd255, 3'd3);
		send_usage(FUNC_SAMPLE, 8'd10, 3'd4);
		send_usage(FUNC_SAMPLE, 8'd3, 3'd5);
		send_usage(FUNC_SAMPLE, 8'd255, 3'd0);
		send_usage(FUNC_TICK, 8'd0, 3'd6);
		send_usage(FUNC_TICK, 8'd255, 3'd7);
		send_usage(FUNC_UNUSED, 8'd170, 3'd1);
		send_usage(FUNC_CLEAR, 8'd85, 3'd1);
		// session flag survives the clear: time grows, count does not
		send_usage(FUNC_SAMPLE, 8'd200, 3'd1);
		for (int d = 0; d < 8; d++)
			send_usage(FUNC_UNUSED, 8'(d * 37), 3'(d));
	endtask

	// Day history shifting, day limit, zero and extreme day lengths
	task automatic test_day_rollover;
		send_idle_pct = 22;
		recv_stall_pct = 22;
		write_usage_config(8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd2, 17'd3);
		for (int day = 0; day < 7; day++) begin
			for (int n = 0; n < day % 4; n++) begin
				send_usage(FUNC_SAMPLE, 8'd0, 3'd1);
				send_usage(FUNC_SAMPLE, 8'(5 + n), 3'd1);
			end
			for (int t = 0; t < 3; t++)
				send_usage(FUNC_TICK, 8'd0, 3'((day + t) % 5 + 1));
		end
		// zero day length: every tick ends a day
		write_usage_config(8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 17'd0);
		send_usage(FUNC_SAMPLE, 8'd0, 3'd1);
		send_usage(FUNC_SAMPLE, 8'd9, 3'd1);
		send_usage(FUNC_TICK, 8'd0, 3'd2);
		send_usage(FUNC_TICK, 8'd0, 3'd3);
		write_usage_config(8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'd1);
		send_usage(FUNC_SAMPLE, 8'd0, 3'd1);
		send_usage(FUNC_SAMPLE, 8'd9, 3'd1);
		send_usage(FUNC_TICK, 8'd0, 3'd2);
		send_usage(FUNC_TICK, 8'd0, 3'd3);
		write_usage_config(8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'h1FFFF);
		send_usage(FUNC_TICK, 8'd0, 3'd1);
		send_usage(FUNC_TICK, 8'd0, 3'd2);
	endtask

	// Saturating totals, a time limit lowered below the total, zero and maximum limits
	task automatic test_saturation;
		send_idle_pct = 0;
		recv_stall_pct = 53;
		write_usage_config(8'd10, 32'd300, 32'd3, 16'hFFFF, 17'd86400);
		for (int n = 0; n < 5; n++) begin
			send_usage(FUNC_SAMPLE, 8'd0, 3'd1);
			send_usage(FUNC_SAMPLE, 8'd200, 3'd1);
		end
		write_usage_config(8'd10, 32'd50, 32'd3, 16'hFFFF, 17'd86400);
		send_usage(FUNC_SAMPLE, 8'd210, 3'd1);
		send_usage(FUNC_SAMPLE, 8'd210, 3'd1);
		write_usage_config(8'd0, 32'd0, 32'd0, 16'd0, 17'd86400);
		send_usage(FUNC_CLEAR, 8'd0, 3'd1);
		send_usage(FUNC_SAMPLE, 8'd0, 3'd1);
		send_usage(FUNC_SAMPLE, 8'd40, 3'd1);
		write_usage_config(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'd86400);
		send_usage(FUNC_SAMPLE, 8'd254, 3'd1);
		send_usage(FUNC_SAMPLE, 8'd255, 3'd1);
		send_usage(FUNC_SAMPLE, 8'd255, 3'd1);
	endtask

	// Random sessions, ticks and noise under random settings for one idling phase
	task automatic test_random(input int send_pct, input int recv_pct);
		int                  r;
		logic [FUNC_W-1:0]   f;
		logic [SAMPLE_W-1:0] s;
		logic [SAMPLE_W-1:0] min_s;
		logic [TOTAL_W-1:0]  t_lim;
		logic [TOTAL_W-1:0]  c_lim;
		logic [DAY_W-1:0]    d_lim;
		logic [SPD_W-1:0]    spd;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int half = 0; half < 2; half++) begin
			min_s = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(20));
			case ($urandom_range(3))
				0: t_lim = 32'hFFFF_FFFF;
				1: t_lim = $urandom_range(2000);
				2: t_lim = $urandom();
				default: t_lim = $urandom_range(200);
			endcase
			c_lim = $urandom_range(1) ? 32'hFFFF_FFFF : 32'($urandom_range(30));
			d_lim = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(6));
			spd = ($urandom_range(9) == 0) ? 17'($urandom_range(131071)) : 17'($urandom_range(8));
			write_usage_config(min_s, t_lim, c_lim, d_lim, spd);
			for (int k = 0; k < RANDOM_ITEMS / 2; k++) begin
				// hold off until the pipeline is empty now and then
				if (k == 100 || $urandom_range(149) == 0)
					drain_usage(0);
				r = $urandom_range(99);
				s = 8'($urandom_range(255));
				if (r < 50) begin
					cur_sample = (r < 3) ? cur_sample + 8'($urandom_range(255))
						: cur_sample + 8'($urandom_range(8));
					f = FUNC_SAMPLE;
					s = cur_sample;
				end else if (r < 60) begin
					cur_sample = 8'($urandom_range(cfg_min_session));
					f = FUNC_SAMPLE;
					s = cur_sample;
				end else if (r < 85) begin
					f = FUNC_TICK;
				end else if (r < 89) begin
					f = FUNC_CLEAR;
				end else if (r < 92) begin
					f = FUNC_UNUSED;
				end else begin
					f = FUNC_W'($urandom_range(3));
				end
				send_usage(f, s, 3'($urandom_range(7)));
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed;
		test_day_rollover;
		test_saturation;
		test_random(0, 0);
		test_random(53, 0);
		test_random(0, 53);
		test_random(22, 22);
		recv_stall_pct = 0;
		drain_usage(SETTLE_CYCLES * 2);
		$display("Checked %0d results of %0d transactions under %0d register settings",
			n_checked, n_sent, n_settings);
		$display("with %0d day rollovers, saturation, clears and four idling phases", n_rollovers);
		if (mismatch_count == 0 && expected_usage.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ues_pkg.sv
sv/usage_event_statistics_top.sv
tb/tb.sv
